>>> rtl/dsrt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsrt_pkg: shared types and constants for the dual servo ramp
// Speed type, the stage-one result record, command codes and the
// fixed-point constants of the pulse-width mapping.
// ----------------------------------------------------------------------------
package dsrt_pkg;

  typedef logic signed [8:0] speed_t;

  // Command codes carried in the input item
  localparam logic CMD_SET  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_TIMEOUT   = 2'd0;
  localparam logic [1:0] CFG_STEP_LOW  = 2'd1;
  localparam logic [1:0] CFG_STEP_HIGH = 2'd2;

  // Configuration reset values
  localparam logic [15:0] TIMEOUT_RST   = 16'd50;
  localparam logic [31:0] STEP_LOW_RST  = 32'd201852163;
  localparam logic [31:0] STEP_HIGH_RST = 32'd504960015;

  // Bucket index is |speed| >> BUCKET_SHIFT, capped at the last bucket
  localparam int unsigned BUCKET_SHIFT = 5;

  localparam speed_t SPEED_MAX = 9'sd255;
  localparam speed_t SPEED_MIN = -9'sd255;

  // Pulse mapping: us = (s + 255) * 2000 / 510, i.e. x * 200 / 51
  localparam logic [7:0]  US_SCALE   = 8'd200;
  localparam logic [18:0] RECIP_51   = 19'd328966;   // ceil(2^24 / 51)
  localparam int unsigned RECIP_51_SH = 24;
  localparam logic [11:0] US_MIN     = 12'd500;
  localparam logic [11:0] US_MAX     = 12'd2500;

  // Duty: us * 16383 / 20000 = ((us * 16383) >> 5) / 625
  localparam logic [20:0] RECIP_625  = 21'd1717987;  // ceil(2^30 / 625)
  localparam int unsigned RECIP_625_SH = 30;

  typedef struct packed {
    logic   vld;
    speed_t speed_l;
    speed_t speed_r;
    logic   timed;
  } dsrt_res_t;

endpackage
`default_nettype wire

>>> rtl/dsrt_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsrt_if: valid/ready channels of the dual servo ramp
// Input item channel (command and two requests) and result channel
// (two pin duty words and the timeout flag).
// ----------------------------------------------------------------------------
interface dsrt_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic signed [15:0] left_request;
  logic signed [15:0] right_request;

  modport source (output valid, command, left_request, right_request, input ready);
  modport sink   (input valid, command, left_request, right_request, output ready);
endinterface

interface dsrt_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] left_pin_duty;
  logic [10:0] right_pin_duty;
  logic        timed_out;

  modport source (output valid, left_pin_duty, right_pin_duty, timed_out, input ready);
  modport sink   (input valid, left_pin_duty, right_pin_duty, timed_out, output ready);
endinterface
`default_nettype wire

>>> rtl/dsrt_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsrt_core: goal, speed and watchdog state of the dual servo ramp
// Applies one item per enabled cycle and loads the new speed pair into the
// stage-one result register on a tick, while armed, when it differs from the last applied pair.
// ----------------------------------------------------------------------------
module dsrt_core (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     cfg_we,
  input  wire  [1:0]              cfg_index,
  input  wire  [31:0]             cfg_data,
  input  wire                     item_fire,
  input  wire                     item_command,
  input  wire  signed [15:0]      item_left,
  input  wire  signed [15:0]      item_right,
  input  wire                     res_take,
  output dsrt_pkg::dsrt_res_t     res
);
  import dsrt_pkg::*;

  logic [15:0] timeout_r;
  logic [31:0] step_low_r;
  logic [31:0] step_high_r;

  speed_t      goal_l_r, goal_l_nxt;
  speed_t      goal_r_r, goal_r_nxt;
  speed_t      speed_l_r, speed_l_nxt;
  speed_t      speed_r_r, speed_r_nxt;
  logic [15:0] idle_r, idle_nxt;
  logic        armed_r, armed_nxt;
  speed_t      appl_l_r, appl_l_nxt;
  speed_t      appl_r_r, appl_r_nxt;
  logic        appl_vld_r, appl_vld_nxt;
  dsrt_res_t   res_r, res_nxt;

  function automatic speed_t clamp_req(input logic signed [15:0] v);
    if (v > 16'sd255) begin
      return SPEED_MAX;
    end
    if (v < -16'sd255) begin
      return SPEED_MIN;
    end
    return speed_t'(v[8:0]);
  endfunction

  function automatic speed_t ramp(input speed_t spd, input speed_t goal,
                                  input logic [63:0] tbl);
    logic [7:0]         mag;
    logic [7:0]         bkt;
    logic [2:0]         idx;
    logic [7:0]         st;
    logic signed [10:0] up;
    logic signed [10:0] dn;
    speed_t             nxt;
    mag = spd[8] ? 8'(-spd) : spd[7:0];
    bkt = mag >> BUCKET_SHIFT;
    idx = (bkt > 8'd7) ? 3'd7 : bkt[2:0];
    st  = tbl[{idx, 3'b000} +: 8];
    up  = 11'(spd) + $signed({3'b000, st});
    dn  = 11'(spd) - $signed({3'b000, st});
    nxt = spd;
    if (spd < goal) begin
      nxt = (up > 11'(goal)) ? goal : speed_t'(up[8:0]);
    end else if (spd > goal) begin
      nxt = (dn < 11'(goal)) ? goal : speed_t'(dn[8:0]);
    end
    return nxt;
  endfunction

  // Configuration registers; the user must write them only while the block is idle (not enforced here)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= TIMEOUT_RST;
      step_low_r  <= STEP_LOW_RST;
      step_high_r <= STEP_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TIMEOUT:   timeout_r   <= cfg_data[15:0];
        CFG_STEP_LOW:  step_low_r  <= cfg_data;
        CFG_STEP_HIGH: step_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic        timed;
    logic [15:0] idle_inc;
    speed_t      gl;
    speed_t      gr;
    speed_t      sl;
    speed_t      sr;
    goal_l_nxt   = goal_l_r;
    goal_r_nxt   = goal_r_r;
    speed_l_nxt  = speed_l_r;
    speed_r_nxt  = speed_r_r;
    idle_nxt     = idle_r;
    armed_nxt    = armed_r;
    appl_l_nxt   = appl_l_r;
    appl_r_nxt   = appl_r_r;
    appl_vld_nxt = appl_vld_r;
    res_nxt      = res_r;
    if (res_take) begin
      res_nxt.vld = 1'b0;
    end

    idle_inc = (idle_r == 16'hFFFF) ? idle_r : idle_r + 16'd1;
    timed    = idle_inc > timeout_r;
    gl       = timed ? '0 : goal_l_r;
    gr       = timed ? '0 : goal_r_r;
    sl       = ramp(speed_l_r, gl, {step_high_r, step_low_r});
    sr       = ramp(speed_r_r, gr, {step_high_r, step_low_r});

    if (item_fire) begin
      if (item_command == CMD_SET) begin
        goal_l_nxt = clamp_req(item_left);
        goal_r_nxt = clamp_req(item_right);
        armed_nxt  = 1'b1;
        idle_nxt   = '0;
      end else if (armed_r) begin
        idle_nxt    = idle_inc;
        goal_l_nxt  = gl;
        goal_r_nxt  = gr;
        // Disarm on the pre-ramp speeds
        if (timed && speed_l_r == '0 && speed_r_r == '0) begin
          armed_nxt = 1'b0;
        end
        speed_l_nxt = sl;
        speed_r_nxt = sr;
        if (!(appl_vld_r && sl == appl_l_r && sr == appl_r_r)) begin
          appl_l_nxt      = sl;
          appl_r_nxt      = sr;
          appl_vld_nxt    = 1'b1;
          res_nxt.vld     = 1'b1;
          res_nxt.speed_l = sl;
          res_nxt.speed_r = sr;
          res_nxt.timed   = timed;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_l_r   <= '0;
      goal_r_r   <= '0;
      speed_l_r  <= '0;
      speed_r_r  <= '0;
      idle_r     <= '0;
      armed_r    <= 1'b0;
      appl_l_r   <= '0;
      appl_r_r   <= '0;
      appl_vld_r <= 1'b0;
      res_r      <= '0;
    end else begin
      goal_l_r   <= goal_l_nxt;
      goal_r_r   <= goal_r_nxt;
      speed_l_r  <= speed_l_nxt;
      speed_r_r  <= speed_r_nxt;
      idle_r     <= idle_nxt;
      armed_r    <= armed_nxt;
      appl_l_r   <= appl_l_nxt;
      appl_r_r   <= appl_r_nxt;
      appl_vld_r <= appl_vld_nxt;
      res_r      <= res_nxt;
    end
  end

  assign res = res_r;

endmodule
`default_nettype wire

>>> rtl/dsrt_duty.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsrt_duty: speed-to-duty mapping pipeline
// Stage two turns each speed into a pulse width in microseconds, the output
// stage scales the width to an 11-bit PWM duty word (16383 full scale) at 50 Hz.
// ----------------------------------------------------------------------------
module dsrt_duty (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire dsrt_pkg::dsrt_res_t res,
  output logic                    res_take,
  input  wire                     out_ready,
  output logic                    out_valid,
  output logic [10:0]             out_left_duty,
  output logic [10:0]             out_right_duty,
  output logic                    out_timed
);
  import dsrt_pkg::*;

  logic        s2_vld_r, s2_vld_nxt;
  logic [11:0] s2_us_l_r;
  logic [11:0] s2_us_r_r;
  logic        s2_timed_r;
  logic        o_vld_r, o_vld_nxt;
  logic [10:0] o_duty_l_r;
  logic [10:0] o_duty_r_r;
  logic        o_timed_r;
  logic        adv_o;
  logic        adv_s2;
  logic [10:0] q_l;
  logic [10:0] q_r;
  logic [10:0] duty_l;
  logic [10:0] duty_r;

  // floor((s + 255) * 200 / 51) by reciprocal, exact for the speed range
  function automatic logic [10:0] us_offset(input speed_t s);
    logic [9:0]  x;
    logic [17:0] n;
    logic [36:0] p;
    x = 10'(11'(s) + 11'sd255);
    n = 18'(x) * 18'(US_SCALE);
    p = 37'(n) * 37'(RECIP_51);
    return p[RECIP_51_SH +: 11];
  endfunction

  // floor(us * 16383 / 20000) by shift-subtract and reciprocal
  function automatic logic [10:0] width_to_duty(input logic [11:0] us);
    logic [25:0] n;
    logic [20:0] ns;
    logic [41:0] p;
    n  = {us, 14'b0} - 26'(us);
    ns = n[25:5];
    p  = 42'(ns) * 42'(RECIP_625);
    return p[RECIP_625_SH +: 11];
  endfunction

  assign adv_o    = !o_vld_r || out_ready;
  assign adv_s2   = !s2_vld_r || adv_o;
  assign res_take = adv_s2;

  // Channels swap: left pin follows right speed, right pin is inverted
  assign q_l = us_offset(res.speed_r);
  assign q_r = us_offset(res.speed_l);

  assign duty_l = width_to_duty(s2_us_l_r);
  assign duty_r = width_to_duty(s2_us_r_r);

  assign s2_vld_nxt = adv_s2 ? res.vld : s2_vld_r;
  assign o_vld_nxt  = adv_o ? s2_vld_r : o_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
      o_vld_r  <= 1'b0;
    end else begin
      s2_vld_r <= s2_vld_nxt;
      o_vld_r  <= o_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_s2 && res.vld) begin
      s2_us_l_r  <= US_MIN + 12'(q_l);
      s2_us_r_r  <= US_MAX - 12'(q_r);
      s2_timed_r <= res.timed;
    end
    if (adv_o && s2_vld_r) begin
      o_duty_l_r <= duty_l;
      o_duty_r_r <= duty_r;
      o_timed_r  <= s2_timed_r;
    end
  end

  assign out_valid      = o_vld_r;
  assign out_left_duty  = o_duty_l_r;
  assign out_right_duty = o_duty_r_r;
  assign out_timed      = o_timed_r;

endmodule
`default_nettype wire

>>> rtl/dual_servo_ramp_with_timeout_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dual_servo_ramp_with_timeout_core: two-channel servo slew limiter
// Ramps two servo speeds toward commanded targets with a command watchdog
// and emits swapped, one-side-inverted PWM duty words on every change.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch   valid/ready item channel. command = set carries two requests
//           (clamped to -255..255) and rearms the watchdog; command = tick
//           is one 10 ms control step.
//   out_ch  valid/ready result channel: left/right pin duty words and the
//           timed_out flag. Only an armed tick whose speed pair differs from the
//           last pair sent (or is the first since reset) transfers; sets never do.
//   cfg_*   write-only registers: timeout, step table low and high words.
//           Write only while no item is in flight.
// Path: an input transfer passes the input register, the state update, the
//   pulse-width stage and the duty stage before out_ch.valid rises for its result.
// Throughput: one item per cycle while out_ch.ready is high; the state update
//   is a loop through the speed and goal registers.
// Reset: synchronous; rst_n low at a clock edge clears the state, disarms the
//   block and restores the register defaults. No clearing pass is needed.
// Stall: when out_ch.ready is low the pipeline fills and in_ch.ready drops
//   only once every stage holds a waiting item; no transfer is lost.
// ----------------------------------------------------------------------------
module dual_servo_ramp_with_timeout_core (
  input  wire         clk,
  input  wire         rst_n,
  dsrt_in_if.sink     in_ch,
  dsrt_out_if.source  out_ch,
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_index,
  input  wire  [31:0] cfg_data
);
  import dsrt_pkg::*;

  // Input register
  logic               in_vld_r, in_vld_nxt;
  logic               in_cmd_r;
  logic signed [15:0] in_left_r;
  logic signed [15:0] in_right_r;

  logic      adv_in;
  logic      res_take;
  dsrt_res_t res;

  // Advance the input register when the stage-one result slot frees up
  assign adv_in      = !res.vld || res_take;
  assign in_ch.ready = !in_vld_r || adv_in;
  assign in_vld_nxt  = in_ch.ready ? in_ch.valid : in_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  // Capture the payload on each input transfer
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_cmd_r   <= in_ch.command;
      in_left_r  <= in_ch.left_request;
      in_right_r <= in_ch.right_request;
    end
  end

  dsrt_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_fire    (in_vld_r && adv_in),
    .item_command (in_cmd_r),
    .item_left    (in_left_r),
    .item_right   (in_right_r),
    .res_take     (res_take),
    .res          (res)
  );

  dsrt_duty u_duty (
    .clk            (clk),
    .rst_n          (rst_n),
    .res            (res),
    .res_take       (res_take),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_left_duty  (out_ch.left_pin_duty),
    .out_right_duty (out_ch.right_pin_duty),
    .out_timed      (out_ch.timed_out)
  );

endmodule
`default_nettype wire
